// ===== sv/graph_diameter_two_check_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graph diameter-two checker
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DIAMETER_TWO_CHECK_DEFINES_SVH
`define GRAPH_DIAMETER_TWO_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define GDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define GDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define GDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/gdt_pkg.sv =====
// ----------------------------------------------------------------------------
// gdt_pkg
// Shared constants, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package gdt_pkg;

    // Graph capacity and field widths
    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int ROW_W        = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int STATUS_W     = 2;

    // Vertex count after reset
    localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

    // Input item kinds (tuser)
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] STATUS_DIAM2    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAR      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;     // write the input row
        logic              rd_en;    // read a row from the table
        logic [ADDR_W-1:0] rd_addr;
        logic              clr;      // clear the missing flag
        logic              cap;      // read data is row v: start its reach set
        logic              acc;      // read data is row u: merge if u neighbors v
        logic [ADDR_W-1:0] sel_idx;  // v during cap, u during acc
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic              reach_full;  // reach set of v covers every vertex
        logic              missing;     // some vertex lacks a one-step cover
        logic [ADDR_W-1:0] last_idx;    // highest vertex in use
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/gdt_dp.sv =====
// ----------------------------------------------------------------------------
// gdt_dp
// Datapath: vertex count register, adjacency row table and reach set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_diameter_two_check_defines.svh"

module gdt_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gdt_pkg::CNT_W-1:0]    i_cfg_data,
    input  wire logic [gdt_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [gdt_pkg::ROW_W-1:0]    i_row_bits,
    input  wire gdt_pkg::t_dp_cmd             i_cmd,
    output gdt_pkg::t_dp_stat                 o_stat
);

    logic [gdt_pkg::CNT_W-1:0]  r_cfg;
    logic [gdt_pkg::ROW_W-1:0]  r_mem [gdt_pkg::MAX_VERTICES];
    logic [gdt_pkg::ROW_W-1:0]  r_rd_data;
    logic [gdt_pkg::ROW_W-1:0]  r_row_v;
    logic [gdt_pkg::ROW_W-1:0]  r_reach;
    logic                       r_missing;

    logic [gdt_pkg::CNT_W-1:0]  w_count;
    logic [gdt_pkg::ROW_W-1:0]  w_mask;
    logic [gdt_pkg::ROW_W-1:0]  w_self;
    logic [gdt_pkg::ROW_W-1:0]  w_start;
    logic [gdt_pkg::ROW_W-1:0]  w_rd_masked;
    logic                       w_wr_en;

    // Hold the vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= gdt_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Clamp the count into the supported range
    always_comb begin
        if (r_cfg == '0) begin
            w_count = gdt_pkg::CNT_W'(1);
        end else if (r_cfg > gdt_pkg::CNT_W'(gdt_pkg::MAX_VERTICES)) begin
            w_count = gdt_pkg::CNT_W'(gdt_pkg::MAX_VERTICES);
        end else begin
            w_count = r_cfg;
        end
    end

    // Build the all-vertices mask
    always_comb begin
        for (int i = 0; i < gdt_pkg::ROW_W; i++) begin
            w_mask[i] = (gdt_pkg::CNT_W'(i) < w_count);
        end
    end

    assign w_self      = gdt_pkg::ROW_W'(1) << i_cmd.sel_idx;
    assign w_rd_masked = r_rd_data & w_mask;
    assign w_start     = (r_rd_data | w_self) & w_mask;

    // Drop loads addressed beyond the table
    assign w_wr_en = i_cmd.load &&
                     (gdt_pkg::CNT_W'(i_row_index) < gdt_pkg::CNT_W'(gdt_pkg::MAX_VERTICES));

    // Row table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_row_index[gdt_pkg::ADDR_W-1:0]] <= i_row_bits;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // Start the reach set of v, then merge neighbor rows into it
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_row_v <= w_rd_masked;
            r_reach <= w_start;
        end else if (i_cmd.acc && r_row_v[i_cmd.sel_idx]) begin
            r_reach <= r_reach | w_rd_masked;
        end
    end

    // Track whether any vertex misses a one-step cover
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_missing <= 1'b0;
        end else if (i_cmd.clr) begin
            r_missing <= 1'b0;
        end else if (i_cmd.cap && (w_start != w_mask)) begin
            r_missing <= 1'b1;
        end
    end

    // Report status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.reach_full = (r_reach == w_mask);
        o_stat.missing    = r_missing;
        o_stat.last_idx   = gdt_pkg::ADDR_W'(w_count - gdt_pkg::CNT_W'(1));
    end

    // A fresh reach set always holds the vertex itself
    `GDT_ASSERT_NEXT(a_self_in_reach, i_clk, i_rst_n, i_cmd.cap, r_reach[$past(i_cmd.sel_idx)])
    // The count stays inside the supported range
    `GDT_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1,
                      (w_count != '0) && (w_count <= gdt_pkg::CNT_W'(gdt_pkg::MAX_VERTICES)))
    // Clearing wins over a miss in the same cycle
    `GDT_ASSERT_NEXT(a_clr_missing, i_clk, i_rst_n, i_cmd.clr, !r_missing)

endmodule

`default_nettype wire

// ===== sv/gdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdt_ctrl
// Controller: accepts items, sequences the vertex/neighbor walk, owns result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_diameter_two_check_defines.svh"

module gdt_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_mode,
    output logic                                 o_in_ready,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [gdt_pkg::STATUS_W-1:0]         o_out_status,
    output gdt_pkg::t_dp_cmd                     o_cmd,
    input  wire gdt_pkg::t_dp_stat               i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDV,
        S_CAPV,
        S_SCAN,
        S_CHK,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [gdt_pkg::ADDR_W-1:0]      r_v;
    logic [gdt_pkg::ADDR_W-1:0]      r_u;
    logic [gdt_pkg::STATUS_W-1:0]    r_result;
    logic                            r_out_valid;
    logic [gdt_pkg::STATUS_W-1:0]    r_out_status;

    logic w_accept;
    logic w_start_eval;
    logic w_u_last;
    logic w_slot_free;
    logic w_post;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = o_in_ready && i_in_valid;
    assign w_start_eval = w_accept && (i_in_mode == gdt_pkg::MODE_EVAL);
    assign w_u_last     = (r_u == i_stat.last_idx);
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_post       = (r_state == S_DONE) && w_slot_free;
    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;

    // Decode datapath commands from the state
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_accept && (i_in_mode == gdt_pkg::MODE_LOAD);
        o_cmd.clr     = w_start_eval;
        o_cmd.sel_idx = r_u;
        unique case (r_state)
            S_RDV: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_v;
            end
            S_CAPV: begin
                o_cmd.cap     = 1'b1;
                o_cmd.sel_idx = r_v;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = '0;
            end
            S_SCAN: begin
                o_cmd.acc     = 1'b1;
                o_cmd.rd_en   = !w_u_last;
                o_cmd.rd_addr = r_u + gdt_pkg::ADDR_W'(1);
            end
            S_IDLE, S_CHK, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // State, counters and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v         <= '0;
            r_u         <= '0;
            r_result    <= gdt_pkg::STATUS_DIAM2;
            r_out_valid <= 1'b0;
        end else begin
            // Post a finished result, drop it once taken
            r_out_valid <= w_post || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_start_eval) begin
                        r_v     <= '0;
                        r_state <= S_RDV;
                    end
                end
                S_RDV: begin
                    r_state <= S_CAPV;
                end
                S_CAPV: begin
                    r_u     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_u_last) begin
                        r_state <= S_CHK;
                    end else begin
                        r_u <= r_u + gdt_pkg::ADDR_W'(1);
                    end
                end
                S_CHK: begin
                    priority if (!i_stat.reach_full) begin
                        r_result <= gdt_pkg::STATUS_FAR;
                        r_state  <= S_DONE;
                    end else if (r_v == i_stat.last_idx) begin
                        r_result <= i_stat.missing ? gdt_pkg::STATUS_DIAM2
                                                   : gdt_pkg::STATUS_COMPLETE;
                        r_state  <= S_DONE;
                    end else begin
                        r_v     <= r_v + gdt_pkg::ADDR_W'(1);
                        r_state <= S_RDV;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_status <= r_result;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result with a free slot is posted and the controller goes idle
    `GDT_ASSERT_NEXT(a_done_posts, i_clk, i_rst_n, w_post, r_out_valid && (r_state == S_IDLE))
    // An accepted evaluation starts the walk at vertex zero
    `GDT_ASSERT_NEXT(a_eval_starts, i_clk, i_rst_n, w_start_eval, (r_state == S_RDV) && (r_v == '0))
    // The neighbor scan finishes on the last vertex
    `GDT_ASSERT_IMPLY(a_scan_complete, i_clk, i_rst_n, r_state == S_CHK, r_u == i_stat.last_idx)

endmodule

`default_nettype wire

// ===== sv/graph_diameter_two_check.sv =====
// ----------------------------------------------------------------------------
// graph_diameter_two_check
// Loads adjacency rows of a graph and reports whether its diameter is two.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                     payload
//  s        in         i_s_tvalid / o_s_tready       tdata: row_index, row_bits; tuser: mode
//  m        out        o_m_tvalid / i_m_tready       tdata: status
//  cfg      in         i_cfg_valid / o_cfg_ready     vertex_count
//
//  A load transaction writes the row into the row table.
//  An evaluation ends early when a vertex is out of reach; per vertex it
//  makes one row-table read of its row, then one read per candidate
//  neighbor through the single read port.
//  Reset restores vertex_count to 64; the row table is not cleared.
//  A pending result does not block loads or a new evaluation; the walk waits
//  at its end only while the previous result has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_diameter_two_check (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Item input
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [71:0]                 i_s_tdata,   // row_index[5:0], row_bits[69:6], zero
    input  wire logic                        i_s_tuser,   // mode[0]
    // Result output
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [7:0]                       o_m_tdata,   // status[1:0], zero
    // Configuration write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [gdt_pkg::CNT_W-1:0]   i_cfg_data
);

    gdt_pkg::t_dp_cmd                 w_cmd;
    gdt_pkg::t_dp_stat                w_stat;
    logic [gdt_pkg::STATUS_W-1:0]     w_status;

    // Always take configuration writes
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {(8 - gdt_pkg::STATUS_W)'(0), w_status};

    gdt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .i_in_mode    (i_s_tuser),
        .o_in_ready   (o_s_tready),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_status (w_status),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    gdt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_row_index  (i_s_tdata[5:0]),
        .i_row_bits   (i_s_tdata[69:6]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

endmodule

`default_nettype wire

// ===== tb/graph_diameter_two_check_checker.sv =====
// ----------------------------------------------------------------------------
// graph_diameter_two_check_checker
// Watches the item, result and configuration channels of the diameter-two
// checker. Keeps its own copy of the adjacency rows and the vertex count,
// predicts the status of every evaluate transaction and compares each result
// transaction, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module graph_diameter_two_check_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    input  wire logic                      i_s_tready,
    input  wire logic [71:0]               i_s_tdata,   // row_index[5:0], row_bits[69:6], zero
    input  wire logic                      i_s_tuser,   // mode[0]
    input  wire logic                      i_m_tvalid,
    input  wire logic                      i_m_tready,
    input  wire logic [7:0]                i_m_tdata,   // status[1:0], zero
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [gdt_pkg::CNT_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gdt_pkg::*;

    logic [ROW_W-1:0]    adj_rows [MAX_VERTICES];
    logic [CNT_W-1:0]    vertex_count = CFG_RESET;
    logic [STATUS_W-1:0] status_queue [$];
    int                  mismatches = 0;

    // Walk every vertex in use and build its two-step reach set
    function automatic logic [STATUS_W-1:0] diameter_status();
        int unsigned      n;
        logic [ROW_W-1:0] all_mask;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] reach;
        bit               short_of_one_step;
        n = vertex_count;
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        all_mask = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
        short_of_one_step = 1'b0;
        for (int unsigned v = 0; v < n; v++) begin
            row   = adj_rows[v] & all_mask;
            reach = row | (ROW_W'(1) << v);
            if (reach != all_mask) short_of_one_step = 1'b1;
            for (int unsigned u = 0; u < n; u++) begin
                if (row[u]) reach |= adj_rows[u] & all_mask;
            end
            if (reach != all_mask) return STATUS_FAR;
        end
        return short_of_one_step ? STATUS_DIAM2 : STATUS_COMPLETE;
    endfunction

    // Sample all channels at the edge; retire results before new predictions
    always @(posedge i_clk) begin
        logic [STATUS_W-1:0] want;
        if (!i_rst_n) begin
            vertex_count = CFG_RESET;
            status_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (status_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction: expected none, actual status %0d",
                             $time, i_m_tdata[STATUS_W-1:0]);
                    mismatches++;
                end else begin
                    want = status_queue.pop_front();
                    if (i_m_tdata[STATUS_W-1:0] !== want) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want, i_m_tdata[STATUS_W-1:0]);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) vertex_count = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == MODE_LOAD) begin
                    adj_rows[i_s_tdata[IDX_W-1:0]] = i_s_tdata[IDX_W +: ROW_W];
                end else begin
                    status_queue.push_back(diameter_status());
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= status_queue.size();
    end

endmodule

// ===== tb/graph_diameter_two_check_tb.sv =====
// ----------------------------------------------------------------------------
// graph_diameter_two_check_tb
// Drives row loads, evaluations and vertex-count writes into the diameter-two
// checker with random gaps on both channels. A directed opening covers the
// tiny graphs and count corner cases, then random phases load whole graphs
// of several shapes, edit them and evaluate again. The checker module does
// the prediction; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module graph_diameter_two_check_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gdt_pkg::*;

    localparam int ITEM_TARGET   = 450;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 200;

    typedef enum int {
        GRAPH_DENSE,
        GRAPH_SPARSE,
        GRAPH_COMPLETE,
        GRAPH_NEAR_COMPLETE,
        GRAPH_STAR,
        GRAPH_RING
    } t_graph_kind;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic [71:0]      s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tready  = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             s_tready;
    logic             m_tvalid;
    logic [7:0]       m_tdata;
    logic             cfg_ready;
    int               fail_count;
    int               pending;

    logic [CNT_W-1:0]        count_shadow = CFG_RESET;
    logic [MAX_VERTICES-1:0] loaded_rows  = '0;
    bit                      burst        = 1'b0;
    int                      items_sent   = 0;
    int                      stall_left   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    graph_diameter_two_check u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    graph_diameter_two_check_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int active_count();
        int n;
        n = count_shadow;
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] full_mask(int n);
        return (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    endfunction

    // Row v of a graph of the given shape; bits beyond the count are junk
    function automatic logic [ROW_W-1:0] make_row(t_graph_kind kind, int v, int n);
        logic [ROW_W-1:0] all_mask;
        logic [ROW_W-1:0] junk;
        logic [ROW_W-1:0] sparse;
        logic [ROW_W-1:0] body;
        all_mask = full_mask(n);
        junk     = {$urandom, $urandom} & ~all_mask;
        sparse   = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        case (kind)
            GRAPH_DENSE: begin
                body = {$urandom, $urandom};
            end
            GRAPH_SPARSE: begin
                body = sparse;
            end
            GRAPH_COMPLETE: begin
                body = all_mask;
                if ($urandom_range(0, 1) == 0) body[v] = 1'b0;
            end
            GRAPH_NEAR_COMPLETE: begin
                body = all_mask;
                if ($urandom_range(0, 3) == 0) body[$urandom_range(0, n - 1)] = 1'b0;
            end
            GRAPH_STAR: begin
                body = (v == 0) ? all_mask : (ROW_W'(1) | sparse);
            end
            GRAPH_RING: begin
                body = (ROW_W'(1) << ((v + 1) % n)) | (ROW_W'(1) << ((v + n - 1) % n));
            end
            default: begin
                body = '0;
            end
        endcase
        return (body & all_mask) | junk;
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic [ROW_W-1:0] bits);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, bits, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic load_row(input int idx, input logic [ROW_W-1:0] bits);
        if (idx < active_count()) items_sent++;
        loaded_rows[idx] = 1'b1;
        send_item(MODE_LOAD, IDX_W'(idx), bits);
    endtask

    // Fill any row in use that was never loaded, then evaluate
    task automatic run_eval();
        int n;
        n = active_count();
        for (int i = 0; i < n; i++) begin
            if (!loaded_rows[i]) load_row(i, {$urandom, $urandom});
        end
        items_sent++;
        send_item(MODE_EVAL, IDX_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic load_graph(input t_graph_kind kind);
        int n;
        bit reverse;
        int v;
        n       = active_count();
        reverse = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            v = reverse ? (n - 1 - i) : i;
            load_row(v, make_row(kind, v, n));
        end
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid    <= 1'b0;
        count_shadow = value;
    endtask

    // Result side: random stalls, none during burst stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!burst && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int               phase;
        int               bigs;
        int               edits;
        int               r;
        int               n;
        bit               big;
        logic [CNT_W-1:0] value;
        t_graph_kind      kind;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count 0 acts as a single vertex; all-ones row with junk above it
        write_count(CNT_W'(0));
        load_row(0, '1);
        run_eval();
        // Top row index is outside the count and ignored
        load_row(MAX_VERTICES - 1, '0);
        load_row(0, '0);
        run_eval();

        // Path 0-1-2, junk above the count in row 2
        write_count(CNT_W'(3));
        load_row(0, 64'h2);
        load_row(1, 64'h5);
        load_row(2, 64'hFFFF_FFFF_FFFF_FFFA);
        run_eval();
        // Vertex 2 loses its only outgoing step
        load_row(2, 64'h0);
        run_eval();

        // Two vertices, one edge each way, then one-way with a self bit
        write_count(CNT_W'(2));
        load_row(0, 64'h2);
        load_row(1, 64'h1);
        run_eval();
        load_row(1, 64'h2);
        run_eval();

        // Random phases: mostly small graphs, a few at full width
        phase = 0;
        bigs  = 0;
        while (items_sent < ITEM_TARGET) begin
            big = (phase == 2 || phase == 12 || (bigs < 4 && $urandom_range(0, 40) == 0));
            if (big) begin
                case (bigs)
                    0:       value = CNT_W'(127);
                    1:       value = CNT_W'(64);
                    default: value = CNT_W'($urandom_range(65, 126));
                endcase
                bigs++;
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0)      value = CNT_W'(0);
                else if (r == 1) value = CNT_W'(1);
                else             value = CNT_W'($urandom_range(2, 12));
            end
            write_count(value);
            burst = ($urandom_range(0, 3) == 0);
            n     = active_count();
            kind  = t_graph_kind'($urandom_range(0, 5));
            load_graph(kind);
            run_eval();
            edits = big ? 1 : $urandom_range(1, 5);
            repeat (edits) begin
                r = $urandom_range(0, 9);
                if (r <= 5) begin
                    load_row($urandom_range(0, n - 1),
                             make_row(t_graph_kind'($urandom_range(0, 5)),
                                      $urandom_range(0, n - 1), n));
                end else if (r <= 7 && n < MAX_VERTICES) begin
                    load_row($urandom_range(n, MAX_VERTICES - 1), {$urandom, $urandom});
                end else if (r == 8) begin
                    wait_idle();
                end else begin
                    load_graph(t_graph_kind'($urandom_range(0, 5)));
                end
                run_eval();
            end
            phase++;
        end

        // Drain and give the verdict
        burst = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/gdt_pkg.sv
sv/gdt_dp.sv
sv/gdt_ctrl.sv
sv/graph_diameter_two_check.sv
tb/graph_diameter_two_check_checker.sv
tb/graph_diameter_two_check_tb.sv
